// ===== sv/chained_pointer_fixup_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the chained pointer fixup decoder
// Concurrent checks on clk. CPFD_ASSERT is disabled while arst_n is low;
// CPFD_ASSERT_ALWAYS is not. Both vanish when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef CHAINED_POINTER_FIXUP_DECODER_ASSERT_SVH
`define CHAINED_POINTER_FIXUP_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CPFD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("cpfd check failed");
`define CPFD_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("cpfd check failed");
`else
`define CPFD_ASSERT(lbl, prop)
`define CPFD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== sv/cpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cpfd_pkg
// Shared types and constants of the chained pointer fixup decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpfd_pkg;

	localparam int unsigned IMPORT_SLOTS_DEFAULT = 1024;
	localparam int unsigned ORD_W = 24;

	localparam logic [3:0] FMT_ARM64E          = 4'd1;
	localparam logic [3:0] FMT_GENERIC64       = 4'd2;
	localparam logic [3:0] FMT_GENERIC64_OFFSET = 4'd6;
	localparam logic [3:0] FMT_ARM64E_USER24   = 4'd12;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	localparam int unsigned GENERIC_STRIDE_SH = 2;
	localparam int unsigned ARM64E_STRIDE_SH  = 3;

	typedef enum logic [1:0] {
		REG_POINTER_FORMAT = 2'd0,
		REG_ACTUAL_BASE    = 2'd1,
		REG_PREFERRED_BASE = 2'd2
	} reg_index_t;

	// arm64e slot kind, taken from the top two bits of the word.
	typedef enum logic [1:0] {
		SLOT_REBASE      = 2'b00,
		SLOT_BIND        = 2'b01,
		SLOT_AUTH_REBASE = 2'b10,
		SLOT_AUTH_BIND   = 2'b11
	} slot_kind_t;

	typedef struct packed {
		logic [3:0]  fmt;
		logic [63:0] actual_base;
		logic [63:0] slide;
	} cfg_t;

endpackage

// ===== sv/chained_pointer_fixup_decoder.sv =====
// ----------------------------------------------------------------------------
// chained_pointer_fixup_decoder
// Loads resolved import addresses and decodes 64-bit chained fixup slots.
// ----------------------------------------------------------------------------
//  channel   handshake                      payload
//  input     start, busy                    kind, slot_word, slot_address,
//                                           entry_index, entry_value
//  result    result_valid (strobe)          fixed_value ... ordinal_out_of_range
//  config    cfg_valid, cfg_ready           cfg_index, cfg_data
//
//  One request is taken every cycle; busy stays low.
//  A decode request passes the registered import table read port and then the
//  registered value add before its result appears. A load gives none.
//  Reset sets the format to 1 and both bases to 0; table entries hold
//  garbage until loaded. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chained_pointer_fixup_decoder
	import cpfd_pkg::*;
#(
	parameter int unsigned IMPORT_SLOTS = IMPORT_SLOTS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [63:0] slot_word,
	input  logic [63:0] slot_address,
	input  logic [9:0]  entry_index,
	input  logic [63:0] entry_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        result_valid,
	output logic [63:0] fixed_value,
	output logic        needs_signing,
	output logic [1:0]  signing_key,
	output logic [15:0] signing_diversity,
	output logic        address_blended,
	output logic [63:0] next_slot_address,
	output logic        end_of_chain,
	output logic        ordinal_out_of_range
);

	localparam int unsigned ADDR_W = (IMPORT_SLOTS > 1) ? $clog2(IMPORT_SLOTS) : 1;
	localparam logic [ORD_W:0] SLOTS_W = (ORD_W + 1)'(IMPORT_SLOTS);

	cfg_t              cfg;
	logic              accept;
	logic              is_generic;
	logic              is_bind;
	logic [ORD_W-1:0]  ordinal;
	logic [ORD_W-1:0]  load_idx;
	logic              load_ok;
	logic [63:0]       table_data;

	logic              valid_s1;
	logic [63:0]       word_s1;
	logic [63:0]       addr_s1;
	logic              bad_s1;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	cpfd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign is_generic = (cfg.fmt == FMT_GENERIC64) || (cfg.fmt == FMT_GENERIC64_OFFSET);
	assign is_bind    = is_generic ? slot_word[63] : slot_word[62];

	// Generic binds and the 24-bit arm64e format use a 24-bit ordinal.
	assign ordinal = (is_generic || cfg.fmt == FMT_ARM64E_USER24)
		? slot_word[ORD_W-1:0] : {8'b0, slot_word[15:0]};

	assign load_idx = ORD_W'(entry_index);
	assign load_ok  = ((ORD_W + 1)'(entry_index) < SLOTS_W);

	cpfd_table #(
		.DEPTH  (IMPORT_SLOTS),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk   (clk),
		.we    (accept && kind == KIND_LOAD && load_ok),
		.waddr (load_idx[ADDR_W-1:0]),
		.wdata (entry_value),
		.re    (accept && kind == KIND_DECODE),
		.raddr (ordinal[ADDR_W-1:0]),
		.rdata (table_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && kind == KIND_DECODE;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && kind == KIND_DECODE) begin
			word_s1 <= slot_word;
			addr_s1 <= slot_address;
			bad_s1  <= is_bind && ({1'b0, ordinal} >= SLOTS_W);
		end
	end

	cpfd_resolve u_resolve (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg                  (cfg),
		.valid_s1             (valid_s1),
		.word_s1              (word_s1),
		.addr_s1              (addr_s1),
		.bad_s1               (bad_s1),
		.table_data           (table_data),
		.result_valid         (result_valid),
		.fixed_value          (fixed_value),
		.needs_signing        (needs_signing),
		.signing_key          (signing_key),
		.signing_diversity    (signing_diversity),
		.address_blended      (address_blended),
		.next_slot_address    (next_slot_address),
		.end_of_chain         (end_of_chain),
		.ordinal_out_of_range (ordinal_out_of_range)
	);

endmodule

// ===== sv/cpfd_cfg.sv =====
// ----------------------------------------------------------------------------
// cpfd_cfg
// Configuration registers; keeps the slide up to date on every base write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpfd_cfg
	import cpfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data,
	output cfg_t        cfg
);

	logic [3:0]  fmt_q;
	logic [63:0] actual_q;
	logic [63:0] preferred_q;
	logic [63:0] slide_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q       <= FMT_ARM64E;
			actual_q    <= '0;
			preferred_q <= '0;
			slide_q     <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_POINTER_FORMAT: begin
					fmt_q <= wr_data[3:0];
				end
				REG_ACTUAL_BASE: begin
					actual_q <= wr_data;
					slide_q  <= wr_data - preferred_q;
				end
				REG_PREFERRED_BASE: begin
					preferred_q <= wr_data;
					slide_q     <= actual_q - wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.fmt         = fmt_q;
	assign cfg.actual_base = actual_q;
	assign cfg.slide       = slide_q;

endmodule

// ===== sv/cpfd_table.sv =====
// ----------------------------------------------------------------------------
// cpfd_table
// Resolved import table: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpfd_table
	import cpfd_pkg::*;
#(
	parameter int unsigned DEPTH  = IMPORT_SLOTS_DEFAULT,
	parameter int unsigned ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [63:0]       wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [63:0]       rdata
);

	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/cpfd_resolve.sv =====
// ----------------------------------------------------------------------------
// cpfd_resolve
// Second stage: combines the slot word with the table data and registers
// the result for its one-cycle strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpfd_resolve
	import cpfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        valid_s1,
	input  logic [63:0] word_s1,
	input  logic [63:0] addr_s1,
	input  logic        bad_s1,
	input  logic [63:0] table_data,
	output logic        result_valid,
	output logic [63:0] fixed_value,
	output logic        needs_signing,
	output logic [1:0]  signing_key,
	output logic [15:0] signing_diversity,
	output logic        address_blended,
	output logic [63:0] next_slot_address,
	output logic        end_of_chain,
	output logic        ordinal_out_of_range
);

	`include "chained_pointer_fixup_decoder_assert.svh"

	logic        generic;
	slot_kind_t  skind;
	logic [63:0] op_a;
	logic [63:0] op_b;
	logic [63:0] sum;
	logic        sign;
	logic [11:0] next_delta;
	logic [63:0] step;

	logic        valid_q;
	logic [63:0] value_q;
	logic        sign_q;
	logic [1:0]  key_q;
	logic [15:0] div_q;
	logic        blend_q;
	logic [63:0] next_q;
	logic        end_q;
	logic        bad_q;

	assign generic = (cfg.fmt == FMT_GENERIC64) || (cfg.fmt == FMT_GENERIC64_OFFSET);
	assign skind   = slot_kind_t'(word_s1[63:62]);

	// Every kind comes down to one 64-bit add; only the operands differ.
	// Preferred base plus slide equals the actual base, so the authenticated
	// rebase adds its target to the actual base directly.
	always_comb begin
		op_a = '0;
		op_b = '0;
		sign = 1'b0;
		if (generic) begin
			if (!word_s1[63]) begin
				op_a = {word_s1[43:36], 20'b0, word_s1[35:0]};
				op_b = (cfg.fmt == FMT_GENERIC64_OFFSET) ? cfg.actual_base : cfg.slide;
			end else begin
				op_a = table_data;
				op_b = {56'b0, word_s1[31:24]};
			end
		end else begin
			case (skind)
				SLOT_REBASE: begin
					op_a = {word_s1[50:43], 13'b0, word_s1[42:0]};
					op_b = (cfg.fmt == FMT_ARM64E) ? cfg.slide : cfg.actual_base;
				end
				SLOT_BIND: begin
					op_a = table_data;
					op_b = {{45{word_s1[50]}}, word_s1[50:32]};
				end
				SLOT_AUTH_REBASE: begin
					op_a = {32'b0, word_s1[31:0]};
					op_b = cfg.actual_base;
					sign = 1'b1;
				end
				SLOT_AUTH_BIND: begin
					op_a = table_data;
					sign = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign sum        = op_a + op_b;
	assign next_delta = generic ? word_s1[62:51] : {1'b0, word_s1[61:51]};
	assign step       = generic ? {50'b0, next_delta, 2'b0} : {49'b0, next_delta, 3'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			value_q <= bad_s1 ? '0 : sum;
			sign_q  <= sign;
			key_q   <= sign ? word_s1[50:49] : 2'b00;
			div_q   <= sign ? word_s1[47:32] : 16'h0000;
			blend_q <= sign ? word_s1[48] : 1'b0;
			next_q  <= addr_s1 + step;
			end_q   <= (next_delta == '0);
			bad_q   <= bad_s1;
		end
	end

	assign result_valid         = valid_q;
	assign fixed_value          = value_q;
	assign needs_signing        = sign_q;
	assign signing_key          = key_q;
	assign signing_diversity    = div_q;
	assign address_blended      = blend_q;
	assign next_slot_address    = next_q;
	assign end_of_chain         = end_q;
	assign ordinal_out_of_range = bad_q;

	`CPFD_ASSERT(a_valid_follows_s1, valid_q |-> $past(valid_s1))
	`CPFD_ASSERT(a_bad_zero, (valid_q && bad_q) |-> (value_q == '0))
	`CPFD_ASSERT(a_unsigned_clean,
		(valid_q && !sign_q) |-> (key_q == 2'b00 && div_q == 16'h0000 && !blend_q))
	`CPFD_ASSERT(a_bad_only_bind, (valid_q && bad_q) |-> !(sign_q && !$past(word_s1[62])))

endmodule
